FILE: rtl/sfr_pkg.sv
// Shared types and constants for the slowest-frame retention block.
// Used by sfr_front, sfr_back and the top level slowest_frame_retention.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int CYC_W     = 32;
    localparam int FN_W      = 32;
    localparam int IDX_IN_W  = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 136;

    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic
    {
        REQ_BOUNDARY = 1'b0,
        REQ_READ     = 1'b1
    } req_kind_t;

    // Classified command handed from front to back
    typedef struct packed
    {
        req_kind_t             kind;
        logic                  rd_ok;   // slot index within range
        logic [IDX_IN_W-1:0]   idx;
        logic [CYC_W-1:0]      cyc;
        logic [CYC_W-1:0]      start;   // cycle count with zero mapped to one
    } cmd_t;

    // Result beat, last field in the lowest bits
    typedef struct packed
    {
        logic [2:0]            pad;
        logic [FN_W-1:0]       read_frame_number;
        logic [CYC_W-1:0]      read_duration;
        logic [FN_W-1:0]       new_frame_number;
        logic [IDX_IN_W-1:0]   staging_slot;
        logic [CYC_W-1:0]      ended_duration;
        logic                  opened_only;
        logic                  kept;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/sfr_front.sv
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on sfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfr_front
    import sfr_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire logic [S_TDATA_W-1:0]  s_data,
    input  wire logic                  s_user,
    output      logic                  q_valid,
    output      cmd_t                  q_cmd,
    input  wire logic                  q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = $clog2(SLOTS + 1) + IDX_IN_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    cmd_t               q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    cmd_t               cmd_in;
    logic               push;
    logic               pop;

    always_comb
    begin
        cmd_in.kind  = req_kind_t'(s_user);
        cmd_in.idx   = s_data[CYC_W +: IDX_IN_W];
        cmd_in.cyc   = s_data[CYC_W-1:0];
        cmd_in.start = (cmd_in.cyc == '0) ? CYC_W'(1) : cmd_in.cyc;
        cmd_in.rd_ok = (CMP_W'(cmd_in.idx) < CMP_W'(SLOTS));
    end

    assign s_ready = (cnt_reg != CNT_FULL);
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = q_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sfr_back.sv
// Back end: slot memories, minimum scan and retention decision, result register.
// Depends on sfr_pkg; takes commands from sfr_front.
`timescale 1ns / 1ps
`default_nettype none

module sfr_back
    import sfr_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  wire cmd_t   q_cmd,
    output      logic   q_pop,
    output      logic   m_valid,
    input  wire logic   m_ready,
    output      result_t m_data
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t             state_reg;
    logic [IDX_W-1:0]   stage_slot_reg;
    logic [FILL_W-1:0]  filled_reg;
    logic [FN_W-1:0]    frame_ctr_reg;
    logic [CYC_W-1:0]   start_reg;
    cmd_t               cmd_reg;
    logic [CYC_W-1:0]   dur_reg;
    logic [FILL_W-1:0]  scan_reg;
    logic               cmp_vld_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [CYC_W-1:0]   min_reg;
    logic [IDX_W-1:0]   min_idx_reg;
    logic               m_valid_reg;
    result_t            m_data_reg;

    // slot stores with per-entry valid bits; an invalid entry reads as zero
    logic [CYC_W-1:0]   dur_mem [SLOTS];
    logic [FN_W-1:0]    fn_mem  [SLOTS];
    logic [SLOTS-1:0]   dur_vld_reg;
    logic [SLOTS-1:0]   fn_vld_reg;
    logic [CYC_W-1:0]   rd_dur_reg;
    logic [FN_W-1:0]    rd_fn_reg;
    logic               rd_dur_ok_reg;
    logic               rd_fn_ok_reg;

    logic               out_free;
    logic               is_open;
    logic [CYC_W-1:0]   head_dur;
    logic [FN_W-1:0]    frame_ctr_inc;
    logic               full;
    logic               keep;
    logic [FILL_W-1:0]  filled_new;
    logic [IDX_W-1:0]   cand;
    logic [IDX_W-1:0]   cand_step;
    logic [IDX_W-1:0]   next_slot;
    logic               scan_issue;
    logic [CYC_W-1:0]   rd_dur_val;
    logic [FN_W-1:0]    rd_fn_val;

    logic               dur_we;
    logic [IDX_W-1:0]   dur_waddr;
    logic [CYC_W-1:0]   dur_wdata;
    logic               fn_we;
    logic [IDX_W-1:0]   fn_waddr;
    logic [FN_W-1:0]    fn_wdata;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               out_load;
    result_t            res_next;

    assign out_free      = !m_valid_reg || m_ready;
    assign q_pop         = (state_reg == S_IDLE) && q_valid && out_free;
    assign is_open       = (start_reg == '0);
    assign head_dur      = q_cmd.cyc - start_reg;
    assign frame_ctr_inc = frame_ctr_reg + 1'b1;
    assign scan_issue    = (state_reg == S_SCAN) && (scan_reg < FILL_FULL);
    assign rd_dur_val    = rd_dur_ok_reg ? rd_dur_reg : '0;
    assign rd_fn_val     = rd_fn_ok_reg ? rd_fn_reg : '0;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

    // retention decision; min_reg covers all slots including the one just scored
    always_comb
    begin
        full       = (filled_reg == FILL_FULL);
        keep       = !full || (dur_reg > min_reg);
        filled_new = (keep && !full) ? filled_reg + 1'b1 : filled_reg;
        cand       = (filled_new != FILL_FULL) ? filled_new[IDX_W-1:0] : min_idx_reg;
        cand_step  = (cand == LAST_IDX) ? '0 : cand + 1'b1;
        if (!keep)
        begin
            next_slot = stage_slot_reg;
        end
        else if (cand == stage_slot_reg)
        begin
            next_slot = cand_step;
        end
        else
        begin
            next_slot = cand;
        end
    end

    always_comb
    begin
        dur_we    = 1'b0;
        dur_waddr = stage_slot_reg;
        dur_wdata = head_dur;
        fn_we     = 1'b0;
        fn_waddr  = stage_slot_reg;
        fn_wdata  = frame_ctr_reg;
        rd_en     = 1'b0;
        rd_addr   = IDX_W'(q_cmd.idx);
        out_load  = 1'b0;
        res_next  = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_cmd.kind == REQ_READ)
                    begin
                        rd_en = q_cmd.rd_ok;
                    end
                    else if (is_open)
                    begin
                        fn_we                     = 1'b1;
                        out_load                  = 1'b1;
                        res_next.opened_only      = 1'b1;
                        res_next.staging_slot     = IDX_IN_W'(stage_slot_reg);
                        res_next.new_frame_number = frame_ctr_reg;
                    end
                    else
                    begin
                        dur_we = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                out_load = 1'b1;
                if (cmd_reg.rd_ok)
                begin
                    res_next.read_duration     = rd_dur_val;
                    res_next.read_frame_number = rd_fn_val;
                end
            end
            S_SCAN:
            begin
                rd_en   = scan_issue;
                rd_addr = scan_reg[IDX_W-1:0];
            end
            S_DECIDE:
            begin
                dur_we                    = 1'b1;
                dur_waddr                 = next_slot;
                dur_wdata                 = '0;
                fn_we                     = 1'b1;
                fn_waddr                  = next_slot;
                fn_wdata                  = frame_ctr_inc;
                out_load                  = 1'b1;
                res_next.kept             = keep;
                res_next.ended_duration   = dur_reg;
                res_next.staging_slot     = IDX_IN_W'(next_slot);
                res_next.new_frame_number = frame_ctr_inc;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dur_we)
        begin
            dur_mem[dur_waddr] <= dur_wdata;
        end
        if (fn_we)
        begin
            fn_mem[fn_waddr] <= fn_wdata;
        end
        if (rd_en)
        begin
            rd_dur_reg <= dur_mem[rd_addr];
            rd_fn_reg  <= fn_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_vld_reg   <= '0;
            fn_vld_reg    <= '0;
            rd_dur_ok_reg <= 1'b0;
            rd_fn_ok_reg  <= 1'b0;
        end
        else
        begin
            if (dur_we)
            begin
                dur_vld_reg[dur_waddr] <= 1'b1;
            end
            if (fn_we)
            begin
                fn_vld_reg[fn_waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_dur_ok_reg <= dur_vld_reg[rd_addr];
                rd_fn_ok_reg  <= fn_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            stage_slot_reg <= '0;
            filled_reg     <= '0;
            frame_ctr_reg  <= '0;
            start_reg      <= '0;
            scan_reg       <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            min_reg        <= '1;
            min_idx_reg    <= '0;
            m_valid_reg    <= 1'b0;
            cmd_reg        <= '0;
            dur_reg        <= '0;
            m_data_reg     <= '0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= res_next;
            end
            else if (m_ready)
            begin
                m_valid_reg <= 1'b0;
            end

            cmp_vld_reg <= scan_issue;
            cmp_idx_reg <= scan_reg[IDX_W-1:0];

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        cmd_reg     <= q_cmd;
                        dur_reg     <= head_dur;
                        scan_reg    <= '0;
                        min_reg     <= '1;
                        min_idx_reg <= '0;
                        if (q_cmd.kind == REQ_READ)
                        begin
                            state_reg <= S_READ;
                        end
                        else if (is_open)
                        begin
                            start_reg <= q_cmd.start;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    if (scan_issue)
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                    // strict compare keeps the lowest index on ties
                    if (cmp_vld_reg && (rd_dur_val < min_reg))
                    begin
                        min_reg     <= rd_dur_val;
                        min_idx_reg <= cmp_idx_reg;
                    end
                    if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    filled_reg     <= filled_new;
                    stage_slot_reg <= next_slot;
                    frame_ctr_reg  <= frame_ctr_inc;
                    start_reg      <= cmd_reg.start;
                    state_reg      <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_filled_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_FULL)
        else $error("filled count beyond slot count");

    a_stage_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_slot_reg <= LAST_IDX)
        else $error("staging slot out of range");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!m_valid_reg || m_ready))
        else $error("command taken while result register blocked");

    a_open_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (start_reg != '0) |=> (start_reg != '0))
        else $error("open frame lost its start count");

    a_keep_moves_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && keep) |=> (stage_slot_reg != $past(stage_slot_reg)))
        else $error("kept frame overwritten by next staging slot");

endmodule

`default_nettype wire

FILE: rtl/slowest_frame_retention.sv
// Top level of the slowest-frame retention block: stream ports, front end and back end.
// Depends on sfr_pkg, sfr_front and sfr_back.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the SLOTS slowest frames. Each beat is a frame boundary (tuser 0) carrying the
// free-running cycle count, or a read of one slot (tuser 1); every beat gives one result
// beat. A front queue of two commands takes beats while the back end works or a result
// waits. In the back end an opening boundary stays in S_IDLE, a read passes S_READ, and a
// later boundary passes S_SCAN and S_DECIDE: the minimum search reads the duration store
// one slot per cycle through a single registered read port and one comparator. Slot stores
// come out of reset as zero through per-entry valid bits, so no clearing pass follows reset.
module slowest_frame_retention
    import sfr_pkg::*;
#(
    parameter int SLOTS = 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    // [31:0] cycle_count, [34:32] slot_index, [39:35] zero
    input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  wire logic [0:0]            s_axis_tuser,
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [0] kept, [1] opened_only, [33:2] ended_duration, [36:34] staging_slot,
    // [68:37] new_frame_number, [100:69] read_duration, [132:101] read_frame_number,
    // [135:133] zero
    output      logic [M_TDATA_W-1:0]  m_axis_tdata
);

    logic       q_valid;
    cmd_t       q_cmd;
    logic       q_pop;
    result_t    m_data;

    sfr_front #(
        .SLOTS   (SLOTS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .s_user  (s_axis_tuser[0]),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    sfr_back #(
        .SLOTS   (SLOTS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_data)
    );

    assign m_axis_tdata = M_TDATA_W'(m_data);

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for slowest_frame_retention: frame boundaries and slot reads in,
// checked field by field against an in-bench retention predictor. Depends on sfr_pkg.

module tb;
    import sfr_pkg::*;

    localparam int N_SLOTS     = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 250;   // result count at which the long hold-off starts
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed
    {
        req_kind_t             kind;
        logic [IDX_IN_W-1:0]   idx;
        logic [CYC_W-1:0]      cyc;
    } frame_req_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    slowest_frame_retention #(.SLOTS(N_SLOTS)) i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    // Predictor state
    logic [CYC_W-1:0]  held_dur [N_SLOTS];
    logic [FN_W-1:0]   held_fn [N_SLOTS];
    int                stage_idx = 0;
    int                n_filled = 0;
    logic [FN_W-1:0]   frame_count = '0;
    logic [CYC_W-1:0]  open_start = '0;   // zero: no frame open yet

    frame_req_t   frame_reqs [$];
    result_t      retention_results [$];
    frame_req_t   on_bus;
    logic [31:0]  clock_now = '0;
    logic [31:0]  last_delta = 32'd10;

    int unsigned  n_total = 0;
    int unsigned  n_sent = 0;
    int unsigned  n_results = 0;
    int unsigned  n_errors = 0;
    int unsigned  n_cycles = 0;
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;

    initial
    begin
        for (int i = 0; i < N_SLOTS; i++)
        begin
            held_dur[i] = '0;
            held_fn[i] = '0;
        end
    end

    function automatic int fastest_slot();
        int best;
        best = 0;
        for (int i = 1; i < N_SLOTS; i++)
            if (held_dur[i] < held_dur[best])
                best = i;
        return best;
    endfunction

    function automatic result_t retain_frame(frame_req_t r);
        result_t           res;
        logic [CYC_W-1:0]  dur;
        int                nxt;
        bit                keep;
        res = '0;
        if (r.kind == REQ_READ)
        begin
            if (r.idx < N_SLOTS)
            begin
                res.read_duration = held_dur[r.idx];
                res.read_frame_number = held_fn[r.idx];
            end
            return res;
        end
        if (open_start == '0)
        begin
            held_fn[stage_idx] = frame_count;
            open_start = (r.cyc == '0) ? 32'd1 : r.cyc;
            res.opened_only = 1'b1;
            res.staging_slot = stage_idx[2:0];
            res.new_frame_number = frame_count;
            return res;
        end
        dur = r.cyc - open_start;
        held_dur[stage_idx] = dur;
        // the frame just scored takes part in the minimum search
        keep = (n_filled < N_SLOTS) ? 1'b1 : (dur > held_dur[fastest_slot()]);
        if (keep)
        begin
            if (n_filled < N_SLOTS)
                n_filled++;
            nxt = (n_filled < N_SLOTS) ? n_filled : fastest_slot();
            if (nxt == stage_idx)
                nxt = (nxt + 1) % N_SLOTS;
        end
        else
            nxt = stage_idx;
        frame_count = frame_count + 1;
        held_dur[nxt] = '0;
        held_fn[nxt] = frame_count;
        stage_idx = nxt;
        open_start = (r.cyc == '0) ? 32'd1 : r.cyc;
        res.kept = keep;
        res.ended_duration = dur;
        res.staging_slot = nxt[2:0];
        res.new_frame_number = frame_count;
        return res;
    endfunction

    task automatic add_boundary(input logic [31:0] cyc);
        frame_req_t r;
        r.kind = REQ_BOUNDARY;
        r.idx = IDX_IN_W'($urandom_range(0, 7));
        r.cyc = cyc;
        frame_reqs.push_back(r);
        clock_now = cyc;
    endtask

    task automatic add_read(input int idx);
        frame_req_t r;
        r.kind = REQ_READ;
        r.idx = IDX_IN_W'(idx);
        r.cyc = $urandom;
        frame_reqs.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_errors++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stimulus, then end-of-run check
    initial
    begin
        int sel;
        int durs [8] = '{99, 50, 50, 7, 300, 50, 1000, 2};

        // directed: reads of the zeroed store, zero start count, slot fill with ties,
        // drops, a wrapping duration, extremes of the count
        add_read(0);
        add_read(7);
        add_boundary(32'd0);
        clock_now = 32'd1;
        foreach (durs[i])
            add_boundary(clock_now + durs[i]);
        add_boundary(clock_now + 1);
        add_boundary(clock_now + 50);
        add_boundary(32'hFFFF_FFF0);
        add_boundary(32'h0000_0010);
        add_boundary(32'h0000_0000);
        add_boundary(32'hFFFF_FFFF);
        for (int i = 0; i < N_SLOTS; i++)
            add_read(i);

        for (int n = 0; n < 780; n++)
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0, 1, 2: add_read($urandom_range(0, 7));
                3, 4, 5:
                begin
                    last_delta = $urandom_range(0, 63);
                    add_boundary(clock_now + last_delta);
                end
                6:
                begin
                    last_delta = $urandom_range(0, 20000);
                    add_boundary(clock_now + last_delta);
                end
                7: add_boundary(clock_now + last_delta);   // tie with an earlier frame
                8: add_boundary($urandom);
                default:
                begin
                    last_delta = $urandom;
                    add_boundary(clock_now + last_delta);
                end
            endcase
        end
        n_total = frame_reqs.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (n_sent == n_total && retention_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0 && retention_results.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Sender: idle share depends on run phase
    always @(posedge clk or negedge rst_n)
    begin
        int unsigned pct;
        bit          go;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                retention_results.push_back(retain_frame(on_bus));
                n_sent <= n_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                pct = (n_sent < n_total / 3) ? 27 : (n_sent < 2 * n_total / 3) ? 56 : 0;
                go = (frame_reqs.size() != 0) && ($urandom_range(0, 99) >= pct);
                if (go)
                begin
                    on_bus = frame_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'b0, on_bus.idx, on_bus.cyc};
                    s_tuser <= on_bus.kind;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver and checker; one long hold-off lets the block back up into its input
    always @(posedge clk or negedge rst_n)
    begin
        result_t     got;
        result_t     want;
        int unsigned pct;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata);
                n_results <= n_results + 1;
                if (retention_results.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end
                else
                begin
                    want = retention_results.pop_front();
                    check_field("kept", want.kept, got.kept);
                    check_field("opened_only", want.opened_only, got.opened_only);
                    check_field("ended_duration", want.ended_duration, got.ended_duration);
                    check_field("staging_slot", want.staging_slot, got.staging_slot);
                    check_field("new_frame_number", want.new_frame_number,
                                got.new_frame_number);
                    check_field("read_duration", want.read_duration, got.read_duration);
                    check_field("read_frame_number", want.read_frame_number,
                                got.read_frame_number);
                end
            end
            pct = (n_sent < n_total / 3) ? 56 : (n_sent < 2 * n_total / 3) ? 27 : 0;
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && n_results == HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= pct);
        end
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

endmodule

FILE: files.f
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_back.sv
rtl/slowest_frame_retention.sv
bench/tb.sv
